// ===== rtl/rtec_pkg.sv =====
package rtec_pkg;

   // Widths of the time and count values.
   localparam int TIME_BITS = 48;
   localparam int CNT_BITS = 32;

   // The remainder unit retires one dividend bit per step.
   localparam int DIV_STEPS = TIME_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // Register port geometry: 64-bit data, registers at 8-byte spacing.
   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 64;
   localparam int REG_LSB = 3;

   // Register reset values.
   localparam logic [CNT_BITS-1:0] REPEAT_RESET = '1;
   localparam logic [TIME_BITS-1:0] FIRST_RESET = '0;
   localparam logic [31:0] PERIOD_RESET = 32'd1000;

   // Command codes.
   typedef enum logic [2:0] {
      OP_ARM     = 3'd0,
      OP_TRIGGER = 3'd1,
      OP_PAUSE   = 3'd2,
      OP_RESUME  = 3'd3,
      OP_REVISE  = 3'd4,
      OP_KILL    = 3'd5
   } op_type;

   // Register indexes.
   typedef enum logic [ADDR_BITS-REG_LSB-1:0] {
      REG_REPEAT = 2'd0,
      REG_FIRST  = 2'd1,
      REG_PERIOD = 2'd2
   } reg_idx_type;

   typedef struct packed {
      op_type               op;
      logic [TIME_BITS-1:0] tick;
   } req_type;

   typedef struct packed {
      logic                       fired;
      logic                       finished;
      logic                       killed;
      logic                       pause_taken;
      logic                       resume_taken;
      logic                       is_valid;
      logic                       is_paused;
      logic [TIME_BITS-1:0]       expiry_now;
      logic signed [31:0]         count_left;
      logic [31:0]                fire_total;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic start_div;
      logic step_div;
      logic apply;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_div;
      logic div_last;
   } ctl_status_type;

endpackage

// ===== rtl/rtec_datapath.sv =====
module rtec_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtec_pkg::ctl_cmd_type                cmd,
   output rtec_pkg::ctl_status_type             status,
   input  rtec_pkg::req_type                    req_data,
   output rtec_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rtec_pkg::ADDR_BITS-1:0]       paddr,
   input  logic [rtec_pkg::DATA_BITS-1:0]       pwdata,
   output logic [rtec_pkg::DATA_BITS-1:0]       prdata
);

   localparam int TB = rtec_pkg::TIME_BITS;
   localparam int CB = rtec_pkg::CNT_BITS;
   localparam int DB = rtec_pkg::DATA_BITS;
   localparam int NB = rtec_pkg::DIV_CNT_BITS;

   // Configuration registers.
   logic [31:0]   repeat_ff;
   logic [TB-1:0] first_ff;
   logic [31:0]   period_ff;

   // Channel state.
   logic                 active_ff, active_in;
   logic                 paused_ff, paused_in;
   logic [TB-1:0]        expiry_ff, expiry_in;
   logic signed [31:0]   remaining_ff, remaining_in;
   logic [TB-1:0]        pause_time_ff, pause_time_in;
   logic [CB-1:0]        fire_count_ff, fire_count_in;

   // Event flags of the current request.
   logic [4:0] flags_ff, flags_in;

   // Latched request.
   rtec_pkg::op_type req_op_ff;
   logic [TB-1:0]    req_tick_ff;

   // Remainder unit.
   logic [31:0]   rem_ff, rem_in;
   logic [TB-1:0] late_ff, late_in;
   logic [NB-1:0] cnt_ff, cnt_in;
   logic [32:0]   rem_shift;
   logic [32:0]   rem_diff;
   logic [TB-1:0] late;

   logic                     csr_write;
   rtec_pkg::reg_idx_type    csr_idx;

   rtec_pkg::rsp_type rsp_ff;

   // Register port decode.
   assign csr_write = psel & penable & pwrite;
   assign csr_idx = rtec_pkg::reg_idx_type'(paddr[rtec_pkg::ADDR_BITS-1:rtec_pkg::REG_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff <= rtec_pkg::REPEAT_RESET;
         first_ff <= rtec_pkg::FIRST_RESET;
         period_ff <= rtec_pkg::PERIOD_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            rtec_pkg::REG_REPEAT: repeat_ff <= pwdata[31:0];
            rtec_pkg::REG_FIRST:  first_ff <= pwdata[TB-1:0];
            rtec_pkg::REG_PERIOD: period_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rtec_pkg::REG_REPEAT: prdata = DB'(repeat_ff);
         rtec_pkg::REG_FIRST:  prdata = DB'(first_ff);
         rtec_pkg::REG_PERIOD: prdata = DB'(period_ff);
         default:              prdata = '0;
      endcase
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_op_ff <= req_data.op;
         req_tick_ff <= req_data.tick;
      end
   end

   // Lateness of the expiry; catch-up needs a remainder when it exceeds the period.
   assign late = req_tick_ff - expiry_ff;
   assign status.need_div = (req_op_ff == rtec_pkg::OP_REVISE) && (period_ff != '0) &&
                            !late[TB-1] && (late > TB'(period_ff));
   assign status.div_last = (cnt_ff == NB'(rtec_pkg::DIV_STEPS - 1));

   // Restoring remainder, one dividend bit per step.
   assign rem_shift = {rem_ff, late_ff[TB-1]};
   assign rem_diff = rem_shift - {1'b0, period_ff};

   always_comb begin
      rem_in = rem_ff;
      late_in = late_ff;
      cnt_in = cnt_ff;
      if (cmd.start_div) begin
         rem_in = '0;
         late_in = late;
         cnt_in = '0;
      end else if (cmd.step_div) begin
         rem_in = (rem_shift >= {1'b0, period_ff}) ? rem_diff[31:0] : rem_shift[31:0];
         late_in = {late_ff[TB-2:0], 1'b0};
         cnt_in = cnt_ff + NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      late_ff <= late_in;
      cnt_ff <= cnt_in;
   end

   // Command execution on the channel state.
   always_comb begin
      logic signed [31:0] rem_v;
      rem_v = remaining_ff;
      active_in = active_ff;
      paused_in = paused_ff;
      expiry_in = expiry_ff;
      remaining_in = remaining_ff;
      pause_time_in = pause_time_ff;
      fire_count_in = fire_count_ff;
      flags_in = flags_ff;
      if (cmd.apply) begin
         flags_in = '0;
         case (req_op_ff)
            rtec_pkg::OP_ARM: begin
               active_in = 1'b1;
               paused_in = 1'b0;
               expiry_in = first_ff;
               remaining_in = repeat_ff;
               pause_time_in = '0;
               fire_count_in = '0;
            end
            rtec_pkg::OP_TRIGGER: begin
               if (active_ff) begin
                  expiry_in = expiry_ff + TB'(period_ff);
                  if (remaining_ff != 0) begin
                     if (remaining_ff > 0) begin
                        rem_v = remaining_ff - 32'sd1;
                     end
                     fire_count_in = fire_count_ff + CB'(1);
                     flags_in[4] = 1'b1;
                  end
                  remaining_in = rem_v;
                  if (rem_v == 0) begin
                     active_in = 1'b0;
                     flags_in[3] = 1'b1;
                  end
               end
            end
            rtec_pkg::OP_PAUSE: begin
               if (active_ff && !paused_ff) begin
                  paused_in = 1'b1;
                  pause_time_in = req_tick_ff;
                  flags_in[1] = 1'b1;
               end
            end
            rtec_pkg::OP_RESUME: begin
               if (active_ff && paused_ff) begin
                  expiry_in = expiry_ff + (req_tick_ff - pause_time_ff);
                  paused_in = 1'b0;
                  flags_in[0] = 1'b1;
               end
            end
            rtec_pkg::OP_REVISE: begin
               // Expiry plus the whole periods within the lateness is tick minus remainder.
               if (status.need_div) begin
                  expiry_in = req_tick_ff - TB'(rem_ff);
               end
            end
            rtec_pkg::OP_KILL: begin
               if (active_ff) begin
                  active_in = 1'b0;
                  flags_in[2] = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         paused_ff <= 1'b0;
         expiry_ff <= '0;
         remaining_ff <= '0;
         pause_time_ff <= '0;
         fire_count_ff <= '0;
         flags_ff <= '0;
      end else begin
         active_ff <= active_in;
         paused_ff <= paused_in;
         expiry_ff <= expiry_in;
         remaining_ff <= remaining_in;
         pause_time_ff <= pause_time_in;
         fire_count_ff <= fire_count_in;
         flags_ff <= flags_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.fired <= flags_ff[4];
         rsp_ff.finished <= flags_ff[3];
         rsp_ff.killed <= flags_ff[2];
         rsp_ff.pause_taken <= flags_ff[1];
         rsp_ff.resume_taken <= flags_ff[0];
         rsp_ff.is_valid <= active_ff;
         rsp_ff.is_paused <= paused_ff;
         rsp_ff.expiry_now <= expiry_ff;
         rsp_ff.count_left <= remaining_ff;
         rsp_ff.fire_total <= 32'(fire_count_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/rtec_controller.sv =====
module rtec_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  rtec_pkg::ctl_status_type    status,
   output rtec_pkg::ctl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencing of one request.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.need_div) begin
               cmd.start_div = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.apply = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            cmd.step_div = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.apply = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/repeating_timer_event_channel_core.sv =====
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_data (op, tick)
// rsp       out        rsp_valid / rsp_ready     rsp_data (flags, status, expiry, counts)
// csr       in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One request is handled at a time. Its result is applied to the channel state, then
// enters the output register from ST_RESP; the next request is taken after that write.
// A revise that catches up first runs ST_DIV: 48 steps of the one-bit-per-cycle
// remainder unit over the 48-bit lateness, then ST_FIN applies the new expiry.
// A new request is accepted while the previous result waits in the output register.
// Reset is synchronous and active high; it clears the channel to invalid and
// loads the register reset values. A stalled result holds the sequencer before write-back.
module repeating_timer_event_channel_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rtec_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rtec_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rtec_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [rtec_pkg::DATA_BITS-1:0]   pwdata,
   output logic [rtec_pkg::DATA_BITS-1:0]   prdata,
   output logic                             pready
);

   rtec_pkg::ctl_cmd_type    cmd;
   rtec_pkg::ctl_status_type status;

   assign pready = 1'b1;

   // Sequencer.
   rtec_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Channel state, registers and remainder unit.
   rtec_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata)
   );

   // A request in flight blocks the next one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while one is in flight");

   // A result is written only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result overwrote an undelivered one");

   // Remainder steps and state update never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.step_div && cmd.apply))
      else $error("state updated during remainder steps");

   // The request latch is loaded only from an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (req_valid && req_ready))
      else $error("request latched without handshake");

endmodule
